// ----- rtl/tmqg_pkg.sv -----
package tmqg_pkg;

  localparam int NUM_TILESETS_DEF = 4;

  // Pipelined divider: dividend width and quotient bits per stage
  localparam int DIV_WIDTH = 30;
  localparam int DIV_STEP  = 2;

  localparam logic [31:0] GID_HFLIP = 32'h8000_0000;
  localparam logic [31:0] GID_VFLIP = 32'h4000_0000;
  localparam logic [31:0] GID_DFLIP = 32'h2000_0000;
  localparam logic [31:0] GID_MASK  = 32'h1fff_ffff;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef enum logic [2:0] {
    CFG_MAP_COLUMNS   = 3'd0,
    CFG_CELL_WIDTH    = 3'd1,
    CFG_CELL_HEIGHT   = 3'd2,
    CFG_LAYER_SHIFT_X = 3'd3,
    CFG_LAYER_SHIFT_Y = 3'd4,
    CFG_TILESET_COUNT = 3'd5
  } cfg_idx_e;

  // One finished quad, handed to the corner sequencer
  typedef struct packed {
    logic               hflip;
    logic               vflip;
    logic               dflip;
    logic [1:0]         slot;
    logic [9:0]         col;
    logic [15:0]        row;
    logic signed [19:0] bu;
    logic signed [42:0] bv;
    logic [7:0]         tw;
    logic [7:0]         th;
    logic [19:0]        px;
    logic [19:0]        py;
  } quad_t;

  // Which unflipped corner feeds output corner k
  function automatic logic [1:0] src_corner(input logic [1:0] k, input logic hf,
                                            input logic vf, input logic df);
    logic [3:0][1:0] m;
    logic [1:0]      t;
    m = {CORNER_BL, CORNER_BR, CORNER_TR, CORNER_TL};
    if (df) begin
      t = m[1]; m[1] = m[3]; m[3] = t;
    end
    if (hf) begin
      t = m[0]; m[0] = m[1]; m[1] = t;
      t = m[3]; m[3] = m[2]; m[2] = t;
    end
    if (vf) begin
      t = m[0]; m[0] = m[3]; m[3] = t;
      t = m[1]; m[1] = m[2]; m[2] = t;
    end
    return m[k];
  endfunction

  function automatic logic [17:0] sat18(input logic signed [42:0] v);
    logic [17:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 43'sd262143) begin
      r = '1;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/tmqg_if.sv -----
interface tmqg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] cell_index;
  logic [31:0] raw_gid;
  logic [1:0]  slot;
  logic [28:0] first_gid;
  logic [7:0]  set_tile_width;
  logic [7:0]  set_tile_height;
  logic [7:0]  set_columns;
  logic [7:0]  set_margin;
  logic [7:0]  set_spacing;
  logic signed [7:0] set_offset_x;
  logic signed [7:0] set_offset_y;

  modport source (output valid, kind, cell_index, raw_gid, slot, first_gid, set_tile_width,
                  set_tile_height, set_columns, set_margin, set_spacing, set_offset_x,
                  set_offset_y, input ready);
  modport sink (input valid, kind, cell_index, raw_gid, slot, first_gid, set_tile_width,
                set_tile_height, set_columns, set_margin, set_spacing, set_offset_x,
                set_offset_y, output ready);
endinterface

interface tmqg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic [17:0]        tex_u;
  logic [17:0]        tex_v;
  logic [1:0]         tileset_slot;
  logic [9:0]         cell_col;
  logic [15:0]        cell_row;
  logic               last;

  modport source (output valid, corner, pos_x, pos_y, tex_u, tex_v, tileset_slot, cell_col,
                  cell_row, last, input ready);
  modport sink (input valid, corner, pos_x, pos_y, tex_u, tex_v, tileset_slot, cell_col,
                cell_row, last, output ready);
endinterface

// ----- rtl/tmqg_div.sv -----
module tmqg_div import tmqg_pkg::*; #(
  parameter int Width = DIV_WIDTH,
  parameter int DenW  = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] num_i,
  input  logic [DenW-1:0]  den_i,
  output logic [Width-1:0] quo_o,
  output logic [DenW-1:0]  rem_o
);

  localparam int NumSt = Width / DIV_STEP;

  logic [DenW-1:0]  r_q [NumSt];
  logic [Width-1:0] n_q [NumSt];
  logic [DenW-1:0]  d_q [NumSt];
  logic [DenW-1:0]  r_d [NumSt];
  logic [Width-1:0] n_d [NumSt];

  // Restoring division, quotient bits shift in at the bottom of n
  always_comb begin
    logic [DenW-1:0]  rr;
    logic [Width-1:0] nn;
    logic [DenW-1:0]  dd;
    logic [DenW:0]    ext;
    logic             ge;
    for (int st = 0; st < NumSt; st++) begin
      if (st == 0) begin
        rr = '0;
        nn = num_i;
        dd = den_i;
      end else begin
        rr = r_q[st-1];
        nn = n_q[st-1];
        dd = d_q[st-1];
      end
      for (int b = 0; b < DIV_STEP; b++) begin
        ext = {rr, nn[Width-1]};
        ge  = (ext >= {1'b0, dd});
        nn  = {nn[Width-2:0], ge};
        rr  = ge ? DenW'(ext - {1'b0, dd}) : ext[DenW-1:0];
      end
      r_d[st] = rr;
      n_d[st] = nn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int st = 0; st < NumSt; st++) begin
        r_q[st] <= r_d[st];
        n_q[st] <= n_d[st];
        d_q[st] <= (st == 0) ? den_i : d_q[(st == 0) ? 0 : st-1];
      end
    end
  end

  assign quo_o = n_q[NumSt-1];
  assign rem_o = r_q[NumSt-1];

endmodule

// ----- rtl/tmqg_corner.sv -----
module tmqg_corner import tmqg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  quad_t item_i,
  output logic  item_ready_o,
  tmqg_out_if.source out_o
);

  quad_t       item_q;
  logic        item_v_q;
  logic [1:0]  k_q;
  logic        ov_q;
  logic        load_out;
  logic        take_item;
  logic [1:0]  m;
  logic signed [42:0] bu_ext;
  logic signed [42:0] u_val;
  logic signed [42:0] v_val;
  logic [19:0] px_val;
  logic [19:0] py_val;

  logic [1:0]         corner_q;
  logic [19:0]        pos_x_q;
  logic [19:0]        pos_y_q;
  logic [17:0]        tex_u_q;
  logic [17:0]        tex_v_q;
  logic [1:0]         slot_q;
  logic [9:0]         col_q;
  logic [15:0]        row_q;

  assign load_out     = item_v_q && (!ov_q || out_o.ready);
  assign take_item    = !item_v_q || (load_out && (k_q == CORNER_BL));
  assign item_ready_o = take_item;

  always_comb begin
    m      = src_corner(k_q, item_q.hflip, item_q.vflip, item_q.dflip);
    bu_ext = 43'(item_q.bu);
    u_val  = bu_ext + (((m == CORNER_TR) || (m == CORNER_BR)) ? 43'(item_q.tw) : 43'd0);
    v_val  = item_q.bv + (((m == CORNER_BR) || (m == CORNER_BL)) ? 43'(item_q.th) : 43'd0);
    px_val = item_q.px + (((k_q == CORNER_TR) || (k_q == CORNER_BR)) ? 20'(item_q.tw) : 20'd0);
    py_val = item_q.py + (((k_q == CORNER_BR) || (k_q == CORNER_BL)) ? 20'(item_q.th) : 20'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      k_q      <= CORNER_TL;
      ov_q     <= 1'b0;
    end else begin
      if (take_item) begin
        item_v_q <= item_valid_i;
      end
      if (load_out) begin
        k_q  <= (k_q == CORNER_BL) ? CORNER_TL : k_q + 2'd1;
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_item) begin
      item_q <= item_i;
    end
    if (load_out) begin
      corner_q <= k_q;
      pos_x_q  <= px_val;
      pos_y_q  <= py_val;
      tex_u_q  <= sat18(u_val);
      tex_v_q  <= sat18(v_val);
      slot_q   <= item_q.slot;
      col_q    <= item_q.col;
      row_q    <= item_q.row;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.corner       = corner_q;
  assign out_o.pos_x        = $signed(pos_x_q);
  assign out_o.pos_y        = $signed(pos_y_q);
  assign out_o.tex_u        = tex_u_q;
  assign out_o.tex_v        = tex_v_q;
  assign out_o.tileset_slot = slot_q;
  assign out_o.cell_col     = col_q;
  assign out_o.cell_row     = row_q;
  assign out_o.last         = (corner_q == CORNER_BL);

  a_next_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && (out_o.corner != CORNER_BL) |=>
      out_o.valid && (out_o.corner == $past(out_o.corner) + 2'd1))
    else $error("quad corners out of sequence");

  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (out_o.corner == CORNER_BL)))
    else $error("last flag off the fourth corner");

  a_mid_quad_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_v_q && (k_q != CORNER_TL) |-> ov_q)
    else $error("output register empty in mid quad");

endmodule

// ----- rtl/tile_map_quad_generator.sv -----
// Path: a render beat accepted on the input passes stages 1 and 2, the dividers, stages A, B, C
//   and the corner sequencer to the output; the other three corners follow when the sink is ready.
// Throughput: the single output port gives one corner a beat while the sink is ready;
//   the upstream pipeline (two 15-stage dividers) advances as one and takes a beat only in a
//   cycle where the corner sequencer can take a quad, so it holds while a quad is going out.
// Reset: asynchronous, active low; clears valid bits and config registers (1,16,16,0,0,1).
//   Tileset slots are not reset and hold garbage until loaded.
module tile_map_quad_generator import tmqg_pkg::*; #(
  parameter int NUM_TILESETS = NUM_TILESETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tmqg_in_if.sink     in_i,
  tmqg_out_if.source  out_o
);

  localparam int SlotW  = (NUM_TILESETS > 1) ? $clog2(NUM_TILESETS) : 1;
  localparam int DivLat = DIV_WIDTH / DIV_STEP;

  typedef struct packed {
    logic [7:0]        tw;
    logic [7:0]        th;
    logic [7:0]        cols;
    logic [7:0]        margin;
    logic [7:0]        spacing;
    logic signed [7:0] offx;
    logic signed [7:0] offy;
  } geom_t;

  typedef struct packed {
    logic [2:0] flags;   // hflip, vflip, dflip
    logic [1:0] slot;
    geom_t      geom;
    logic       neg;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0]         map_columns_q;
  logic [7:0]         cell_width_q;
  logic [7:0]         cell_height_q;
  logic signed [15:0] shift_x_q;
  logic signed [15:0] shift_y_q;
  logic [2:0]         tileset_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_columns_q   <= 10'd1;
      cell_width_q    <= 8'd16;
      cell_height_q   <= 8'd16;
      shift_x_q       <= '0;
      shift_y_q       <= '0;
      tileset_count_q <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_COLUMNS:   map_columns_q   <= cfg_data_i[9:0];
        CFG_CELL_WIDTH:    cell_width_q    <= cfg_data_i[7:0];
        CFG_CELL_HEIGHT:   cell_height_q   <= cfg_data_i[7:0];
        CFG_LAYER_SHIFT_X: shift_x_q       <= $signed(cfg_data_i);
        CFG_LAYER_SHIFT_Y: shift_y_q       <= $signed(cfg_data_i);
        CFG_TILESET_COUNT: tileset_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves together whenever the corner sequencer
  // can take a new quad. Loads and empty cells travel as bubbles.
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_acc;

  assign in_i.ready = adv;
  assign in_acc     = in_i.valid && adv;

  // ---------------------------------------------------------------------------
  // Tileset slots: written at accept time so that later loads never reach back
  // into cells already in flight.
  // ---------------------------------------------------------------------------
  logic [28:0] start_q [NUM_TILESETS];
  geom_t       geom_q  [NUM_TILESETS];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.kind && (int'(in_i.slot) < NUM_TILESETS)) begin
      start_q[SlotW'(in_i.slot)] <= in_i.first_gid;
      geom_q[SlotW'(in_i.slot)]  <= '{tw: in_i.set_tile_width, th: in_i.set_tile_height,
                                      cols: in_i.set_columns, margin: in_i.set_margin,
                                      spacing: in_i.set_spacing, offx: in_i.set_offset_x,
                                      offy: in_i.set_offset_y};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0 (accept): tileset search, highest qualifying slot wins
  // ---------------------------------------------------------------------------
  logic [28:0]      id_s0;
  logic [SlotW-1:0] pick_s0;

  assign id_s0 = in_i.raw_gid[28:0];

  always_comb begin
    pick_s0 = '0;
    for (int j = 0; j < NUM_TILESETS; j++) begin
      if ((j < int'(tileset_count_q)) && (start_q[j] <= id_s0)) begin
        pick_s0 = SlotW'(j);
      end
    end
  end

  // Stage 1: hold the chosen slot's descriptor
  logic        s1_v_q;
  logic [2:0]  s1_flags_q;
  logic [1:0]  s1_slot_q;
  logic [28:0] s1_start_q;
  logic [28:0] s1_id_q;
  geom_t       s1_geom_q;
  logic [15:0] s1_cidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_acc && !in_i.kind && ((in_i.raw_gid & GID_MASK) != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_flags_q <= {(in_i.raw_gid & GID_HFLIP) != '0, (in_i.raw_gid & GID_VFLIP) != '0,
                     (in_i.raw_gid & GID_DFLIP) != '0};
      s1_slot_q  <= 2'(pick_s0);
      s1_start_q <= start_q[pick_s0];
      s1_id_q    <= id_s0;
      s1_geom_q  <= geom_q[pick_s0];
      s1_cidx_q  <= in_i.cell_index;
    end
  end

  // Stage 2: local id as sign and magnitude for the divider
  logic [29:0] local_s1;
  logic [29:0] mag_s1;

  assign local_s1 = {1'b0, s1_id_q} - {1'b0, s1_start_q};
  assign mag_s1   = local_s1[29] ? (30'd0 - local_s1) : local_s1;

  logic        s2_v_q;
  side_t       s2_side_q;
  logic [29:0] s2_mag_q;
  logic [15:0] s2_cidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q <= '{flags: s1_flags_q, slot: s1_slot_q, geom: s1_geom_q, neg: local_s1[29]};
      s2_mag_q  <= mag_s1;
      s2_cidx_q <= s1_cidx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers: cell index by map columns, local id by atlas columns. A zero
  // divisor acts as one.
  // ---------------------------------------------------------------------------
  logic [9:0]           map_den;
  logic [7:0]           set_den;
  logic [DIV_WIDTH-1:0] map_quo;
  logic [9:0]           map_rem;
  logic [DIV_WIDTH-1:0] set_quo;
  logic [7:0]           set_rem;

  assign map_den = (map_columns_q == '0) ? 10'd1 : map_columns_q;
  assign set_den = (s2_side_q.geom.cols == '0) ? 8'd1 : s2_side_q.geom.cols;

  tmqg_div #(.Width(DIV_WIDTH), .DenW(10)) u_div_map (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DIV_WIDTH'(s2_cidx_q)),
    .den_i (map_den),
    .quo_o (map_quo),
    .rem_o (map_rem)
  );

  tmqg_div #(.Width(DIV_WIDTH), .DenW(8)) u_div_set (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DIV_WIDTH'(s2_mag_q)),
    .den_i (set_den),
    .quo_o (set_quo),
    .rem_o (set_rem)
  );

  // Side data runs alongside the dividers
  logic  dv_q [DivLat];
  side_t dside_q [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      dv_q[0] <= s2_v_q;
      for (int i = 1; i < DivLat; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= s2_side_q;
      for (int i = 1; i < DivLat; i++) begin
        dside_q[i] <= dside_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: restore signs (truncating division), grid products
  // ---------------------------------------------------------------------------
  side_t             dside;
  logic signed [8:0]  tx_d;
  logic signed [30:0] ty_d;

  assign dside = dside_q[DivLat-1];
  assign tx_d  = dside.neg ? -$signed({1'b0, set_rem}) : $signed({1'b0, set_rem});
  assign ty_d  = dside.neg ? -$signed({1'b0, set_quo}) : $signed({1'b0, set_quo});

  logic               sa_v_q;
  side_t              sa_side_q;
  logic signed [8:0]  sa_tx_q;
  logic signed [30:0] sa_ty_q;
  logic [9:0]         sa_col_q;
  logic [15:0]        sa_row_q;
  logic [17:0]        sa_pcol_q;
  logic [23:0]        sa_prow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else if (adv) begin
      sa_v_q <= dv_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_side_q <= dside;
      sa_tx_q   <= tx_d;
      sa_ty_q   <= ty_d;
      sa_col_q  <= map_rem;
      sa_row_q  <= map_quo[15:0];
      sa_pcol_q <= map_rem * cell_width_q;
      sa_prow_q <= map_quo[15:0] * cell_height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: atlas products, screen position with bottom alignment
  // ---------------------------------------------------------------------------
  logic [8:0]         ustep;
  logic [8:0]         vstep;
  logic signed [18:0] mu_d;
  logic signed [40:0] mv_d;
  logic [19:0]        px_d;
  logic [19:0]        py_d;

  assign ustep = {1'b0, sa_side_q.geom.tw} + {1'b0, sa_side_q.geom.spacing};
  assign vstep = {1'b0, sa_side_q.geom.th} + {1'b0, sa_side_q.geom.spacing};
  assign mu_d  = sa_tx_q * $signed({1'b0, ustep});
  assign mv_d  = sa_ty_q * $signed({1'b0, vstep});
  assign px_d  = 20'(sa_pcol_q) + 20'(sa_side_q.geom.offx) + 20'(shift_x_q);
  assign py_d  = 20'(sa_prow_q) + 20'(sa_side_q.geom.offy) + 20'(shift_y_q)
               + 20'(cell_height_q) - 20'(sa_side_q.geom.th);

  logic               sb_v_q;
  side_t              sb_side_q;
  logic signed [18:0] sb_mu_q;
  logic signed [40:0] sb_mv_q;
  logic [9:0]         sb_col_q;
  logic [15:0]        sb_row_q;
  logic [19:0]        sb_px_q;
  logic [19:0]        sb_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else if (adv) begin
      sb_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_side_q <= sa_side_q;
      sb_mu_q   <= mu_d;
      sb_mv_q   <= mv_d;
      sb_col_q  <= sa_col_q;
      sb_row_q  <= sa_row_q;
      sb_px_q   <= px_d;
      sb_py_q   <= py_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: add the atlas margin, pack the quad
  // ---------------------------------------------------------------------------
  logic  sc_v_q;
  quad_t sc_q;
  logic signed [19:0] bu_d;
  logic signed [42:0] bv_d;

  assign bu_d = 20'(sb_mu_q) + 20'($signed({1'b0, sb_side_q.geom.margin}));
  assign bv_d = 43'(sb_mv_q) + 43'($signed({1'b0, sb_side_q.geom.margin}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (adv) begin
      sc_v_q <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_q <= '{hflip: sb_side_q.flags[2], vflip: sb_side_q.flags[1],
                dflip: sb_side_q.flags[0], slot: sb_side_q.slot, col: sb_col_q,
                row: sb_row_q, bu: bu_d, bv: bv_d, tw: sb_side_q.geom.tw,
                th: sb_side_q.geom.th, px: sb_px_q, py: sb_py_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Corner sequencer: four beats per quad through a registered output
  // ---------------------------------------------------------------------------
  tmqg_corner u_corner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (sc_v_q),
    .item_i       (sc_q),
    .item_ready_o (adv),
    .out_o        (out_o)
  );

endmodule

// ----- tb/sv/tb_tile_map_quad_generator.sv -----
module tb_tile_map_quad_generator import tmqg_pkg::*;;

  // One corner vertex as it should appear on the output channel
  typedef struct {
    logic [1:0]  corner;
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic [17:0] tex_u;
    logic [17:0] tex_v;
    logic [1:0]  tileset_slot;
    logic [9:0]  cell_col;
    logic [15:0] cell_row;
    logic        last;
  } vertex_t;

  // One input beat: render cell or tileset load
  typedef struct {
    logic        kind;
    logic [15:0] cell_index;
    logic [31:0] raw_gid;
    logic [1:0]  slot;
    logic [28:0] first_gid;
    logic [7:0]  tw;
    logic [7:0]  th;
    logic [7:0]  cols;
    logic [7:0]  margin;
    logic [7:0]  spacing;
    logic [7:0]  off_x;
    logic [7:0]  off_y;
    bit          typed;
  } beat_t;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;
  localparam int   SETTLE_CYCLES = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  tmqg_in_if  in_if ();
  tmqg_out_if out_if ();

  tile_map_quad_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // Shadow copy of the block's registers and tileset slots
  logic [9:0]  map_cols_q;
  logic [7:0]  cell_w_q;
  logic [7:0]  cell_h_q;
  logic [15:0] shift_x_q;
  logic [15:0] shift_y_q;
  logic [2:0]  set_count_q;
  logic [28:0] slot_first[4];
  logic [7:0]  slot_tw[4], slot_th[4], slot_cols[4], slot_margin[4], slot_spacing[4];
  logic [7:0]  slot_ox[4], slot_oy[4];

  vertex_t vertex_q[$];
  vertex_t typed_quad[4];
  bit      use_typed;
  bit      quiet;
  int      n_errors;
  logic    in_beat;

  // Clock: period 10
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Saturate an atlas coordinate to the 18-bit output range
  function automatic logic [17:0] clamp_tex(longint v);
    if (v < 0) return '0;
    if (v > 262143) return 18'h3ffff;
    return v[17:0];
  endfunction

  // Work out the four corners of a render beat and queue them
  task automatic queue_quad(logic [15:0] cidx, logic [31:0] raw);
    logic [28:0] id;
    logic [1:0]  pick;
    int          cnt;
    longint      mc, col, row, tw, th, sc, loc, tx, ty, bu, bv, px, py, t;
    longint      pu[4], pv[4];
    vertex_t     v;
    id = raw[28:0];
    if (id == 0) return;
    cnt = (set_count_q > 4) ? 4 : set_count_q;
    pick = 0;
    for (int j = cnt - 1; j >= 0; j--) begin
      if (slot_first[j] <= id) begin
        pick = j[1:0];
        break;
      end
    end
    tw = slot_tw[pick];
    th = slot_th[pick];
    sc = (slot_cols[pick] == 0) ? 1 : slot_cols[pick];
    mc = (map_cols_q == 0) ? 1 : map_cols_q;
    col = cidx % mc;
    row = cidx / mc;
    px = col * longint'(cell_w_q) + longint'($signed(slot_ox[pick]))
         + longint'($signed(shift_x_q));
    py = row * longint'(cell_h_q) + longint'($signed(slot_oy[pick]))
         + longint'($signed(shift_y_q)) + (longint'(cell_h_q) - th);
    loc = longint'(id) - longint'(slot_first[pick]);
    tx = loc % sc;
    ty = loc / sc;
    bu = slot_margin[pick] + tx * (tw + slot_spacing[pick]);
    bv = slot_margin[pick] + ty * (th + slot_spacing[pick]);
    pu[0] = bu;      pv[0] = bv;
    pu[1] = bu + tw; pv[1] = bv;
    pu[2] = bu + tw; pv[2] = bv + th;
    pu[3] = bu;      pv[3] = bv + th;
    // diagonal first, then horizontal, then vertical
    if (raw & GID_DFLIP) begin
      t = pu[1]; pu[1] = pu[3]; pu[3] = t;
      t = pv[1]; pv[1] = pv[3]; pv[3] = t;
    end
    if (raw & GID_HFLIP) begin
      t = pu[0]; pu[0] = pu[1]; pu[1] = t;
      t = pv[0]; pv[0] = pv[1]; pv[1] = t;
      t = pu[3]; pu[3] = pu[2]; pu[2] = t;
      t = pv[3]; pv[3] = pv[2]; pv[2] = t;
    end
    if (raw & GID_VFLIP) begin
      t = pu[0]; pu[0] = pu[3]; pu[3] = t;
      t = pv[0]; pv[0] = pv[3]; pv[3] = t;
      t = pu[1]; pu[1] = pu[2]; pu[2] = t;
      t = pv[1]; pv[1] = pv[2]; pv[2] = t;
    end
    for (int k = 0; k < 4; k++) begin
      t = px + ((k == 1 || k == 2) ? tw : 0);
      v.pos_x = t[19:0];
      t = py + ((k >= 2) ? th : 0);
      v.pos_y = t[19:0];
      v.corner = k[1:0];
      v.tex_u = clamp_tex(pu[k]);
      v.tex_v = clamp_tex(pv[k]);
      v.tileset_slot = pick;
      v.cell_col = col[9:0];
      v.cell_row = row[15:0];
      v.last = (k == 3);
      // hand-worked rows override the computed corners
      vertex_q = {vertex_q, (use_typed ? typed_quad[k] : v)};
    end
  endtask

  // Input monitor: track accepted beats and predict
  always @(posedge clk_i) begin
    in_beat <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (in_if.kind == KIND_LOAD) begin
        slot_first[in_if.slot]   = in_if.first_gid;
        slot_tw[in_if.slot]      = in_if.set_tile_width;
        slot_th[in_if.slot]      = in_if.set_tile_height;
        slot_cols[in_if.slot]    = in_if.set_columns;
        slot_margin[in_if.slot]  = in_if.set_margin;
        slot_spacing[in_if.slot] = in_if.set_spacing;
        slot_ox[in_if.slot]      = in_if.set_offset_x;
        slot_oy[in_if.slot]      = in_if.set_offset_y;
      end else begin
        queue_quad(in_if.cell_index, in_if.raw_gid);
      end
    end
  end

  // Output monitor: compare each vertex beat with the oldest expectation
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (vertex_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected vertex: corner %0d cell %0d,%0d", out_if.corner,
                   out_if.cell_col, out_if.cell_row);
      end else begin
        e = vertex_q.pop_front();
        if (out_if.corner !== e.corner || out_if.pos_x !== e.pos_x ||
            out_if.pos_y !== e.pos_y || out_if.tex_u !== e.tex_u ||
            out_if.tex_v !== e.tex_v || out_if.tileset_slot !== e.tileset_slot ||
            out_if.cell_col !== e.cell_col || out_if.cell_row !== e.cell_row ||
            out_if.last !== e.last) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("vertex mismatch: exp c%0d x%0h y%0h u%0h v%0h s%0d col%0d row%0d l%0b",
                     e.corner, e.pos_x, e.pos_y, e.tex_u, e.tex_v, e.tileset_slot,
                     e.cell_col, e.cell_row, e.last);
            $display("  got c%0d x%0h y%0h u%0h v%0h s%0d col%0d row%0d l%0b",
                     out_if.corner, out_if.pos_x, out_if.pos_y, out_if.tex_u, out_if.tex_v,
                     out_if.tileset_slot, out_if.cell_col, out_if.cell_row, out_if.last);
          end
        end
      end
    end
  end

  // Sink side: stall about one cycle in ten unless in a quiet stretch
  always @(negedge clk_i) begin
    out_if.ready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  // Write one register and mirror it; only called while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAP_COLUMNS:   map_cols_q  = val[9:0];
      CFG_CELL_WIDTH:    cell_w_q    = val[7:0];
      CFG_CELL_HEIGHT:   cell_h_q    = val[7:0];
      CFG_LAYER_SHIFT_X: shift_x_q   = val;
      CFG_LAYER_SHIFT_Y: shift_y_q   = val;
      CFG_TILESET_COUNT: set_count_q = val[2:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] mc, logic [15:0] cw, logic [15:0] ch,
                           logic [15:0] sx, logic [15:0] sy, logic [15:0] tc);
    write_reg(CFG_MAP_COLUMNS, mc);
    write_reg(CFG_CELL_WIDTH, cw);
    write_reg(CFG_CELL_HEIGHT, ch);
    write_reg(CFG_LAYER_SHIFT_X, sx);
    write_reg(CFG_LAYER_SHIFT_Y, sy);
    write_reg(CFG_TILESET_COUNT, tc);
  endtask

  // Drive one beat from a falling edge and hold it until taken
  task automatic send(beat_t b);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    use_typed = b.typed;
    in_if.valid           <= 1'b1;
    in_if.kind            <= b.kind;
    in_if.cell_index      <= b.cell_index;
    in_if.raw_gid         <= b.raw_gid;
    in_if.slot            <= b.slot;
    in_if.first_gid       <= b.first_gid;
    in_if.set_tile_width  <= b.tw;
    in_if.set_tile_height <= b.th;
    in_if.set_columns     <= b.cols;
    in_if.set_margin      <= b.margin;
    in_if.set_spacing     <= b.spacing;
    in_if.set_offset_x    <= b.off_x;
    in_if.set_offset_y    <= b.off_y;
    do @(negedge clk_i); while (!in_beat);
    use_typed = 1'b0;
  endtask

  // Drop valid at once, drain the output, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (vertex_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic beat_t cell_beat(logic [15:0] cidx, logic [31:0] raw);
    beat_t b;
    b = '{default: '0};
    b.kind = KIND_CELL;
    b.cell_index = cidx;
    b.raw_gid = raw;
    return b;
  endfunction

  function automatic beat_t load_beat(logic [1:0] s, logic [28:0] fg, logic [7:0] tw,
                                      logic [7:0] th, logic [7:0] cols, logic [7:0] mg,
                                      logic [7:0] sp, logic [7:0] ox, logic [7:0] oy);
    beat_t b;
    b = '{default: '0};
    b.kind = KIND_LOAD;
    b.slot = s;
    b.first_gid = fg;
    b.tw = tw; b.th = th; b.cols = cols; b.margin = mg; b.spacing = sp;
    b.off_x = ox; b.off_y = oy;
    return b;
  endfunction

  // Random beat: mostly renders, about half of them aimed at the loaded slots, some loads
  function automatic beat_t random_beat();
    beat_t       b;
    logic [28:0] id;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      b = load_beat(2'($urandom_range(0, 3)),
                    ($urandom_range(0, 9) < 7) ? 29'($urandom_range(0, 500)) : 29'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      id = 29'(slot_first[$urandom_range(0, 3)] + $urandom_range(0, 40));
      else if (pick < 70) id = 29'($urandom);
      else if (pick < 78) id = '0;
      else                id = 29'($urandom_range(1, 300));
      b = cell_beat(($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4000)) : 16'($urandom),
                    {3'($urandom), id});
    end
    return b;
  endfunction

  beat_t directed[$];

  initial begin
    n_errors = 0;
    use_typed = 1'b0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAP_COLUMNS;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_CELL;
    in_if.cell_index = '0;
    in_if.raw_gid = '0;
    in_if.slot = '0;
    in_if.first_gid = '0;
    in_if.set_tile_width = '0;
    in_if.set_tile_height = '0;
    in_if.set_columns = '0;
    in_if.set_margin = '0;
    in_if.set_spacing = '0;
    in_if.set_offset_x = '0;
    in_if.set_offset_y = '0;
    // register values after reset
    map_cols_q = 10'd1; cell_w_q = 8'd16; cell_h_q = 8'd16;
    shift_x_q = '0; shift_y_q = '0; set_count_q = 3'd1;

    // Hand-worked quad: 16x16 tile, id 1 at cell 0, registers at reset
    typed_quad[0] = '{CORNER_TL, 20'd0,  20'd0,  18'd0,  18'd0,  2'd0, 10'd0, 16'd0, 1'b0};
    typed_quad[1] = '{CORNER_TR, 20'd16, 20'd0,  18'd16, 18'd0,  2'd0, 10'd0, 16'd0, 1'b0};
    typed_quad[2] = '{CORNER_BR, 20'd16, 20'd16, 18'd16, 18'd16, 2'd0, 10'd0, 16'd0, 1'b0};
    typed_quad[3] = '{CORNER_BL, 20'd0,  20'd16, 18'd0,  18'd16, 2'd0, 10'd0, 16'd0, 1'b1};

    // Directed table: load every slot first so no unloaded slot is ever read
    directed = {directed, load_beat(0, 29'd1, 16, 16, 8, 0, 0, 0, 0)};
    directed = {directed, load_beat(1, 29'd50, 255, 255, 255, 255, 255, 8'sd127, -8'sd128)};
    directed = {directed, load_beat(2, 29'd1000, 1, 1, 1, 0, 0, -8'sd128, 8'sd127)};
    directed = {directed, load_beat(3, 29'h1fffffff, 8, 32, 0, 3, 2, 0, 0)};
    directed = {directed, cell_beat(16'd0, 32'h0000_0000)};          // empty cell
    directed = {directed, cell_beat(16'd0, 32'he000_0000)};          // empty cell, all flips
    directed = {directed, cell_beat(16'd0, 32'h0000_0001)};
    directed[$].typed = 1'b1;
    directed = {directed, cell_beat(16'd3, GID_HFLIP | 32'd2)};
    directed = {directed, cell_beat(16'hffff, GID_VFLIP | 32'd9)};
    directed = {directed, cell_beat(16'd100, GID_DFLIP | 32'd10)};
    directed = {directed, cell_beat(16'd5, 32'he000_0011)};
    directed = {directed, cell_beat(16'hffff, GID_MASK)};            // largest id, saturates
    directed = {directed, cell_beat(16'h8000, 32'hffff_ffff)};
    directed = {directed, load_beat(0, 29'd200, 16, 16, 8, 0, 0, 0, 0)};
    directed = {directed, cell_beat(16'd7, 32'd5)};                  // no slot matches
    directed = {directed, cell_beat(16'd8, GID_HFLIP | GID_DFLIP | 32'd7)};
    directed = {directed, load_beat(0, 29'd1, 16, 16, 8, 0, 0, 0, 0)};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(negedge clk_i);
    foreach (directed[i]) send(directed[i]);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_regs(16'd7, 16'd16, 16'd16, 16'd0, 16'd0, 16'd4);
        1: load_regs(16'd1023, 16'd255, 16'd255, 16'h7fff, 16'h8000, 16'd7);
        2: load_regs(16'hfc00, 16'd1, 16'd1, 16'h8000, 16'h7fff, 16'd0);
        default: begin
          load_regs(16'd1, 16'd8, 16'd200, 16'hfffb, 16'd100, 16'd2);
          // unknown index: must leave every register alone
          write_reg(cfg_idx_e'(CFG_TILESET_COUNT + 3'd1), 16'hffff);
        end
      endcase
      // one long stretch with no stalls on either side
      quiet = (ph == 1);
      @(negedge clk_i);
      repeat (90) send(random_beat());
      drain();
      quiet = 1'b0;
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
